### src/encoder_speed_pwm_regulator_defines.svh
// Assertion helpers used by the checker file.
`ifndef ENCODER_SPEED_PWM_REGULATOR_DEFINES_SVH
`define ENCODER_SPEED_PWM_REGULATOR_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define ESPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define ESPR_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/espr_pkg.sv
`timescale 1ns / 1ps

package espr_pkg;

    // Field widths
    localparam int REQ_W      = 3;
    localparam int WAY_W      = 2;
    localparam int TIME_IN_W  = 32;
    localparam int TGT_W      = 14;
    localparam int DUTY_W     = 10;
    localparam int MEAS_W     = 27;
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int EPU_W      = 4;
    localparam int TMO_W      = 8;

    localparam int TIME_WIDTH_DEF = 32;

    // Slave-side tdata layout: edge_way, edge_time, target_speed
    localparam int I_WAY_LSB  = 0;
    localparam int I_TIME_LSB = I_WAY_LSB + WAY_W;
    localparam int I_TGT_LSB  = I_TIME_LSB + TIME_IN_W;
    localparam int S_TDATA_W  = ((I_TGT_LSB + TGT_W + 7) / 8) * 8;

    // Master-side tdata layout: duty, direction_level, measured_speed, position
    localparam int O_DUTY_LSB  = 0;
    localparam int O_DIR_BIT   = O_DUTY_LSB + DUTY_W;
    localparam int O_SPEED_LSB = O_DIR_BIT + 1;
    localparam int O_POS_LSB   = O_SPEED_LSB + MEAS_W;
    localparam int O_USED_W    = O_POS_LSB + POS_W;
    localparam int M_TDATA_W   = ((O_USED_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Speed numerator and the serial divider/multiplier step counts
    localparam int SPEED_NUM = 60000000;
    localparam int NUM_W     = $clog2(SPEED_NUM + 1);
    localparam int MUL_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2((NUM_W > MUL_STEPS) ? NUM_W : MUL_STEPS);

    // Register reset values
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 10'd1000;
    localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd14549;
    localparam logic [EPU_W-1:0]  EPU_RST      = 4'd11;
    localparam logic [TMO_W-1:0]  TMO_RST      = 8'd5;
    localparam logic              INV_RST      = 1'b1;
    localparam logic              ROT_REV_RST  = 1'b1;
    localparam logic              FWD_RST      = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_EDGE   = 3'd0,
        REQ_LINEAR = 3'd1,
        REQ_ROTATE = 3'd2,
        REQ_STOP   = 3'd3,
        REQ_TICK   = 3'd4
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DUTY  = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_EPU       = 3'd2,
        CFG_TIMEOUT   = 3'd3,
        CFG_INVERT    = 3'd4,
        CFG_ROT_REV   = 3'd5,
        CFG_FWD_LEVEL = 3'd6
    } t_cfg_idx;

endpackage

### src/encoder_speed_pwm_regulator.sv
`timescale 1ns / 1ps
// Encoder speed meter and PWM duty regulator for one wheel.
// Slave channel: one transaction per request. tuser carries req_type (edge,
// linear, rotate, stop, tick); tdata carries edge_way, edge_time, target_speed.
// Master channel: one transaction per request with the wheel state after it:
// duty, direction_level, measured_speed, position.
// Configuration: write i_cfg_wdata to register i_cfg_idx while i_cfg_we is
// high; only while no request is in flight.
// Timing: a request is taken in the idle cycle and goes through a sequencer.
// Stop, tick, unknown and non-wrapping edge requests go from decode straight
// to the push state. A motion command that changes the target runs a shift-add
// multiplier that walks the 16 gain bits one per cycle. An edge that completes
// a divider period runs a restoring divider (skipped when the summed time is
// zero) that retires one quotient bit per cycle over the 26 bits of the speed
// numerator. The result is offered on the master side in the same cycle that
// the slave side is ready again.
// The result lands in an output register; the next request is accepted while
// it waits, and only a second finished result waits for the receiver.
// Reset: configuration takes its defaults, all wheel state clears, no result
// is held and the slave side is ready at once.
module encoder_speed_pwm_regulator #(
    parameter int TIME_WIDTH = espr_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [espr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [espr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // edge_way [1:0], edge_time [33:2], target_speed [47:34]
    input  logic [espr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type [2:0]
    input  logic [espr_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // duty [9:0], direction_level [10], measured_speed [37:11],
    // position [69:38], zero fill [71:70]
    output logic [espr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int TGT_W  = espr_pkg::TGT_W;
    localparam int DUTY_W = espr_pkg::DUTY_W;
    localparam int NUM_W  = espr_pkg::NUM_W;
    localparam int MEAS_W = espr_pkg::MEAS_W;
    localparam int POS_W  = espr_pkg::POS_W;
    localparam int GAIN_W = espr_pkg::GAIN_W;
    localparam int EPU_W  = espr_pkg::EPU_W;
    localparam int TMO_W  = espr_pkg::TMO_W;
    localparam int CNT_W  = espr_pkg::CNT_W;
    localparam int PROD_W = TGT_W + GAIN_W;

    localparam logic [NUM_W-1:0] SPEED_NUM_V = NUM_W'(espr_pkg::SPEED_NUM);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(espr_pkg::MUL_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_APPLY,
        ST_MUL,
        ST_LOAD,
        ST_PUSH
    } t_state;

    // Configuration
    logic [DUTY_W-1:0] r_max_duty;
    logic [GAIN_W-1:0] r_gain;
    logic [EPU_W-1:0]  r_epu;
    logic [TMO_W-1:0]  r_tmo_ticks;
    logic              r_inv;
    logic              r_rot_rev;
    logic              r_fwd;

    // Wheel state
    logic [EPU_W-1:0]       r_phase;
    logic [TIME_WIDTH-1:0]  r_time_sum;
    logic [POS_W-1:0]       r_pos;
    logic [MEAS_W-1:0]      r_speed;
    logic [DUTY_W-1:0]      r_duty;
    logic [TGT_W-1:0]       r_target;
    logic                   r_dir;
    logic [TMO_W-1:0]       r_tmo_left;

    // Request held for the sequencer
    t_state                        r_st;
    espr_pkg::t_req                r_req;
    logic [espr_pkg::WAY_W-1:0]    r_way;
    logic [TIME_WIDTH-1:0]         r_time;
    logic [TGT_W-1:0]              r_spd;

    // Serial arithmetic
    logic [CNT_W-1:0]       r_cnt;
    logic [TIME_WIDTH-1:0]  r_rem;
    logic [NUM_W-1:0]       r_nq;
    logic [PROD_W-1:0]      r_prod;
    logic [TGT_W-1:0]       r_mag;
    logic                   r_up;

    // Output register
    logic                            r_m_valid;
    logic [espr_pkg::M_TDATA_W-1:0]  r_m_data;

    // Next values and helpers
    logic [EPU_W-1:0]       n_div;
    logic                   n_up;
    logic                   n_dn;
    logic [TIME_WIDTH-1:0]  n_sum;
    logic [EPU_W:0]         n_phase_inc;
    logic                   n_up_wrap;
    logic                   n_dn_wrap;
    logic                   n_upd;
    logic [EPU_W-1:0]       n_phase;
    logic [TGT_W-1:0]       n_spd_mag;
    logic [TGT_W-1:0]       n_tgt_mag;
    logic [TIME_WIDTH:0]    n_trial;
    logic [TIME_WIDTH:0]    n_diff;
    logic                   n_fits;
    logic [TIME_WIDTH-1:0]  n_rem;
    logic [TGT_W:0]         n_psum;
    logic [PROD_W-1:0]      n_prod;
    logic [TGT_W-1:0]       n_start_raw;
    logic [DUTY_W-1:0]      n_start;
    logic [NUM_W-1:0]       n_tgt_ext;
    logic [MEAS_W-1:0]      n_speed;
    logic [DUTY_W-1:0]      n_duty_out;
    logic                   n_lvl;
    logic                   n_push;
    logic [espr_pkg::M_TDATA_W-1:0] n_m_data;

    always_comb begin
        // A divider of zero counts as one
        n_div = (r_epu == '0) ? EPU_W'(1) : r_epu;

        // Edge direction: code 1 is up, codes 2 and 3 are down, 0 is no move; inversion swaps up and down
        n_up = r_inv ? r_way[1] : (r_way == 2'b01);
        n_dn = r_inv ? (r_way == 2'b01) : r_way[1];

        n_sum       = r_time_sum + r_time;
        n_phase_inc = {1'b0, r_phase} + (EPU_W + 1)'(1);
        n_up_wrap   = n_phase_inc >= {1'b0, n_div};
        n_dn_wrap   = (r_phase == '0);
        n_upd       = (n_up && n_up_wrap) || (n_dn && n_dn_wrap);

        if (n_up) begin
            n_phase = n_up_wrap ? '0 : n_phase_inc[EPU_W-1:0];
        end else if (n_dn) begin
            n_phase = n_dn_wrap ? (n_div - EPU_W'(1)) : (r_phase - EPU_W'(1));
        end else begin
            n_phase = r_phase;
        end

        n_spd_mag = r_spd[TGT_W-1] ? (TGT_W'(0) - r_spd) : r_spd;
        n_tgt_mag = r_target[TGT_W-1] ? (TGT_W'(0) - r_target) : r_target;

        // One restoring divide step: numerator bit in at the bottom of the remainder
        n_trial = {r_rem, r_nq[NUM_W-1]};
        n_diff  = n_trial - {1'b0, r_time_sum};
        n_fits  = n_trial >= {1'b0, r_time_sum};
        n_rem   = n_fits ? n_diff[TIME_WIDTH-1:0] : n_trial[TIME_WIDTH-1:0];

        // One shift-add step, gain bits consumed from the bottom
        n_psum = {1'b0, r_prod[PROD_W-1:GAIN_W]}
               + (r_prod[0] ? {1'b0, r_mag} : (TGT_W + 1)'(0));
        n_prod = {n_psum, r_prod[GAIN_W-1:1]};

        n_start_raw = r_prod[PROD_W-1:GAIN_W];
        n_start     = (n_start_raw > TGT_W'(r_max_duty)) ? r_max_duty
                                                         : n_start_raw[DUTY_W-1:0];

        n_tgt_ext = NUM_W'(n_tgt_mag);
        n_speed   = r_up ? {1'b0, r_nq} : (MEAS_W'(0) - {1'b0, r_nq});

        n_lvl = r_fwd ^ r_spd[TGT_W-1] ^ ((r_req == espr_pkg::REQ_ROTATE) && r_rot_rev);

        n_duty_out = (r_duty > r_max_duty) ? r_max_duty : r_duty;
        n_push     = (r_st == ST_PUSH) && (!r_m_valid || m_axis_tready);

        n_m_data = '0;
        n_m_data[espr_pkg::O_DUTY_LSB +: DUTY_W]  = n_duty_out;
        n_m_data[espr_pkg::O_DIR_BIT]             = r_dir;
        n_m_data[espr_pkg::O_SPEED_LSB +: MEAS_W] = r_speed;
        n_m_data[espr_pkg::O_POS_LSB +: POS_W]    = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_m_valid   <= 1'b0;
            r_max_duty  <= espr_pkg::MAX_DUTY_RST;
            r_gain      <= espr_pkg::GAIN_RST;
            r_epu       <= espr_pkg::EPU_RST;
            r_tmo_ticks <= espr_pkg::TMO_RST;
            r_inv       <= espr_pkg::INV_RST;
            r_rot_rev   <= espr_pkg::ROT_REV_RST;
            r_fwd       <= espr_pkg::FWD_RST;
            r_phase     <= '0;
            r_time_sum  <= '0;
            r_pos       <= '0;
            r_speed     <= '0;
            r_duty      <= '0;
            r_target    <= '0;
            r_dir       <= 1'b0;
            r_tmo_left  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (espr_pkg::t_cfg_idx'(i_cfg_idx))
                    espr_pkg::CFG_MAX_DUTY:  r_max_duty  <= i_cfg_wdata[DUTY_W-1:0];
                    espr_pkg::CFG_GAIN:      r_gain      <= i_cfg_wdata[GAIN_W-1:0];
                    espr_pkg::CFG_EPU:       r_epu       <= i_cfg_wdata[EPU_W-1:0];
                    espr_pkg::CFG_TIMEOUT:   r_tmo_ticks <= i_cfg_wdata[TMO_W-1:0];
                    espr_pkg::CFG_INVERT:    r_inv       <= i_cfg_wdata[0];
                    espr_pkg::CFG_ROT_REV:   r_rot_rev   <= i_cfg_wdata[0];
                    espr_pkg::CFG_FWD_LEVEL: r_fwd       <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // Output register: load a finished result, drop one the receiver took
            if (n_push) begin
                r_m_valid <= 1'b1;
                r_m_data  <= n_m_data;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req  <= espr_pkg::t_req'(s_axis_tuser);
                        r_way  <= s_axis_tdata[espr_pkg::I_WAY_LSB +: espr_pkg::WAY_W];
                        r_time <= s_axis_tdata[espr_pkg::I_TIME_LSB +: TIME_WIDTH];
                        r_spd  <= s_axis_tdata[espr_pkg::I_TGT_LSB +: TGT_W];
                        r_st   <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    r_st <= ST_PUSH;
                    case (r_req)
                        espr_pkg::REQ_EDGE: begin
                            r_phase    <= n_phase;
                            r_time_sum <= n_sum;
                            r_up       <= n_up;
                            if (n_upd) begin
                                // A zero sum reads as the largest speed
                                if (n_sum == '0) begin
                                    r_nq <= SPEED_NUM_V;
                                    r_st <= ST_APPLY;
                                end else begin
                                    r_nq  <= SPEED_NUM_V;
                                    r_rem <= '0;
                                    r_cnt <= DIV_LAST;
                                    r_st  <= ST_DIV;
                                end
                            end
                        end
                        espr_pkg::REQ_LINEAR, espr_pkg::REQ_ROTATE: begin
                            r_tmo_left <= r_tmo_ticks;
                            // A command equal to the target only re-arms the timeout
                            if (r_spd != r_target) begin
                                r_mag  <= n_spd_mag;
                                r_prod <= {TGT_W'(0), r_gain};
                                r_cnt  <= MUL_LAST;
                                r_st   <= ST_MUL;
                            end
                        end
                        espr_pkg::REQ_STOP: begin
                            if (r_target != '0) begin
                                r_duty   <= '0;
                                r_target <= '0;
                                r_dir    <= r_fwd;
                            end
                        end
                        espr_pkg::REQ_TICK: begin
                            if (r_tmo_left != '0) begin
                                r_tmo_left <= r_tmo_left - TMO_W'(1);
                                // Timeout expiry acts as a stop
                                if (r_tmo_left == TMO_W'(1) && r_target != '0) begin
                                    r_duty   <= '0;
                                    r_target <= '0;
                                    r_dir    <= r_fwd;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_nq  <= {r_nq[NUM_W-2:0], n_fits};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_st <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_speed    <= n_speed;
                    r_pos      <= r_up ? (r_pos + POS_W'(1)) : (r_pos - POS_W'(1));
                    r_time_sum <= '0;
                    // Step the duty one count to bring the measured speed toward the target magnitude
                    if (r_nq > n_tgt_ext) begin
                        if (r_duty != '0) begin
                            r_duty <= r_duty - DUTY_W'(1);
                        end
                    end else if (r_nq < n_tgt_ext) begin
                        if (r_duty < r_max_duty) begin
                            r_duty <= r_duty + DUTY_W'(1);
                        end
                    end
                    r_st <= ST_PUSH;
                end
                ST_MUL: begin
                    r_prod <= n_prod;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_st <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_duty   <= n_start;
                    r_target <= r_spd;
                    r_dir    <= n_lvl;
                    r_st     <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (n_push) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

### src/espr_checker.sv
`timescale 1ns / 1ps
`include "encoder_speed_pwm_regulator_defines.svh"

module espr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [espr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int MEAS_W = espr_pkg::MEAS_W;
    localparam logic signed [MEAS_W-1:0] SPD_MAX = MEAS_W'(espr_pkg::SPEED_NUM);
    localparam logic signed [MEAS_W-1:0] SPD_MIN = MEAS_W'(-espr_pkg::SPEED_NUM);

    logic                     w_in_acc;
    logic                     w_out_acc;
    logic [1:0]               r_pend;
    logic signed [MEAS_W-1:0] w_speed;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_speed   = $signed(m_axis_tdata[espr_pkg::O_SPEED_LSB +: MEAS_W]);

    // Requests accepted whose result is not yet delivered; saturate at three
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            if (r_pend != 2'd3) begin
                r_pend <= r_pend + 2'd1;
            end
        end else if (w_out_acc && !w_in_acc) begin
            if (r_pend != 2'd0) begin
                r_pend <= r_pend - 2'd1;
            end
        end
    end

    `ESPR_ASSERT_NORST(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result held after reset")
    `ESPR_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend <= 2'd2, "more than two requests in flight")
    `ESPR_ASSERT(a_no_phantom, i_clk, i_rst_n, m_axis_tvalid |-> r_pend != 2'd0, "result without request")
    `ESPR_ASSERT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ESPR_ASSERT(a_speed_range, i_clk, i_rst_n, m_axis_tvalid |-> w_speed <= SPD_MAX && w_speed >= SPD_MIN, "speed out of range")

endmodule

bind encoder_speed_pwm_regulator espr_checker u_espr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
